// ===== rtl/core/mce_pkg.sv =====
// Package for the Morse character encoder: segment kinds, register indexes,
// queue entry and timing types, and the fixed International Morse code table.
// No dependencies.
`default_nettype none
package mce_pkg;

    localparam int CODE_MAX_LEN = 6;
    localparam int LEN_W        = $clog2(CODE_MAX_LEN + 1);
    localparam int TIME_W       = 16;
    localparam int CHAR_W       = 8;
    localparam int QUEUE_DEPTH  = 2;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    typedef enum logic [1:0] {
        KIND_DOT        = 2'd0,
        KIND_DASH       = 2'd1,
        KIND_WORD_GAP   = 2'd2,
        KIND_LETTER_GAP = 2'd3
    } seg_kind_t;

    typedef enum logic [2:0] {
        REG_SOUND_ENABLE    = 3'd0,
        REG_DOT_ON_TIME     = 3'd1,
        REG_DASH_ON_TIME    = 3'd2,
        REG_DOT_OFF_TIME    = 3'd3,
        REG_DASH_OFF_TIME   = 3'd4,
        REG_LETTER_GAP_TIME = 3'd5,
        REG_WORD_GAP_TIME   = 3'd6
    } reg_index_t;

    localparam logic [TIME_W-1:0] RESET_DOT_ON_TIME     = 16'd150;
    localparam logic [TIME_W-1:0] RESET_DASH_ON_TIME    = 16'd450;
    localparam logic [TIME_W-1:0] RESET_DOT_OFF_TIME    = 16'd26;
    localparam logic [TIME_W-1:0] RESET_DASH_OFF_TIME   = 16'd1;
    localparam logic [TIME_W-1:0] RESET_LETTER_GAP_TIME = 16'd450;
    localparam logic [TIME_W-1:0] RESET_WORD_GAP_TIME   = 16'd680;

    typedef struct packed {
        logic [TIME_W-1:0] dot_on;
        logic [TIME_W-1:0] dash_on;
        logic [TIME_W-1:0] dot_off;
        logic [TIME_W-1:0] dash_off;
        logic [TIME_W-1:0] letter_gap;
        logic [TIME_W-1:0] word_gap;
    } timing_t;

    // symbols: first symbol in the top bit, 1 = dash
    typedef struct packed {
        logic                    known;
        logic [LEN_W-1:0]        len;
        logic [CODE_MAX_LEN-1:0] symbols;
    } code_t;

    typedef struct packed {
        logic                    word_gap;
        logic [LEN_W-1:0]        elem_count;
        logic [CODE_MAX_LEN-1:0] symbols;
    } entry_t;

    function automatic code_t morse_lookup(input logic [CHAR_W-1:0] ch);
        code_t c;
        c.known = 1'b1;
        case (ch)
            "A": begin c.len = 3'd2; c.symbols = 6'b010000; end
            "B": begin c.len = 3'd4; c.symbols = 6'b100000; end
            "C": begin c.len = 3'd4; c.symbols = 6'b101000; end
            "D": begin c.len = 3'd3; c.symbols = 6'b100000; end
            "E": begin c.len = 3'd1; c.symbols = 6'b000000; end
            "F": begin c.len = 3'd4; c.symbols = 6'b001000; end
            "G": begin c.len = 3'd3; c.symbols = 6'b110000; end
            "H": begin c.len = 3'd4; c.symbols = 6'b000000; end
            "I": begin c.len = 3'd2; c.symbols = 6'b000000; end
            "J": begin c.len = 3'd4; c.symbols = 6'b011100; end
            "K": begin c.len = 3'd3; c.symbols = 6'b101000; end
            "L": begin c.len = 3'd4; c.symbols = 6'b010000; end
            "M": begin c.len = 3'd2; c.symbols = 6'b110000; end
            "N": begin c.len = 3'd2; c.symbols = 6'b100000; end
            "O": begin c.len = 3'd3; c.symbols = 6'b111000; end
            "P": begin c.len = 3'd4; c.symbols = 6'b011000; end
            "Q": begin c.len = 3'd4; c.symbols = 6'b110100; end
            "R": begin c.len = 3'd3; c.symbols = 6'b010000; end
            "S": begin c.len = 3'd3; c.symbols = 6'b000000; end
            "T": begin c.len = 3'd1; c.symbols = 6'b100000; end
            "U": begin c.len = 3'd3; c.symbols = 6'b001000; end
            "V": begin c.len = 3'd4; c.symbols = 6'b000100; end
            "W": begin c.len = 3'd3; c.symbols = 6'b011000; end
            "X": begin c.len = 3'd4; c.symbols = 6'b100100; end
            "Y": begin c.len = 3'd4; c.symbols = 6'b101100; end
            "Z": begin c.len = 3'd4; c.symbols = 6'b110000; end
            "0": begin c.len = 3'd5; c.symbols = 6'b111110; end
            "1": begin c.len = 3'd5; c.symbols = 6'b011110; end
            "2": begin c.len = 3'd5; c.symbols = 6'b001110; end
            "3": begin c.len = 3'd5; c.symbols = 6'b000110; end
            "4": begin c.len = 3'd5; c.symbols = 6'b000010; end
            "5": begin c.len = 3'd5; c.symbols = 6'b000000; end
            "6": begin c.len = 3'd5; c.symbols = 6'b100000; end
            "7": begin c.len = 3'd5; c.symbols = 6'b110000; end
            "8": begin c.len = 3'd5; c.symbols = 6'b111000; end
            "9": begin c.len = 3'd5; c.symbols = 6'b111100; end
            ".": begin c.len = 3'd6; c.symbols = 6'b010101; end
            "!": begin c.len = 3'd6; c.symbols = 6'b101011; end
            "?": begin c.len = 3'd6; c.symbols = 6'b001100; end
            ",": begin c.len = 3'd6; c.symbols = 6'b110011; end
            "-": begin c.len = 3'd6; c.symbols = 6'b100001; end
            "_": begin c.len = 3'd6; c.symbols = 6'b001101; end
            ":": begin c.len = 3'd6; c.symbols = 6'b111000; end
            "/": begin c.len = 3'd5; c.symbols = 6'b100100; end
            default: begin
                c.known   = 1'b0;
                c.len     = '0;
                c.symbols = '0;
            end
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/morse_character_encoder_core.sv =====
// Top level of the Morse character encoder: APB register file, front end,
// entry queue and segment back end. Depends on mce_pkg, mce_front, mce_queue, mce_back.
//
// Characters enter on the s_ channel and leave as timed segments on the m_ channel.
// The back-end sequencer emits one segment per cycle unless m_ready stalls it, so
// a character whose code has n symbols yields n + 1 segments (2 for a character
// outside the table, 1 with sound disabled), at most 7; the front end looks up the
// next character meanwhile and the queue of QUEUE_DEPTH entries lets consecutive
// characters follow without a gap. Registers sit at byte address 4*index; the user
// must write them only while the block is idle, which the block does not enforce.
`default_nettype none
module morse_character_encoder_core
    import mce_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [CHAR_W-1:0]     s_character,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_segment_kind,
    output logic [TIME_W-1:0]          m_tone_time,
    output logic [TIME_W-1:0]          m_silence_time,
    output logic                       m_last_segment
);

    logic       sound_enable_reg;
    timing_t    timing_reg;
    logic       wr_en;
    reg_index_t reg_sel;

    logic   push_valid, push_ready, pop_valid, pop_ready;
    entry_t push_entry, pop_entry;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = reg_index_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sound_enable_reg      <= 1'b1;
            timing_reg.dot_on     <= RESET_DOT_ON_TIME;
            timing_reg.dash_on    <= RESET_DASH_ON_TIME;
            timing_reg.dot_off    <= RESET_DOT_OFF_TIME;
            timing_reg.dash_off   <= RESET_DASH_OFF_TIME;
            timing_reg.letter_gap <= RESET_LETTER_GAP_TIME;
            timing_reg.word_gap   <= RESET_WORD_GAP_TIME;
        end else if (wr_en) begin
            case (reg_sel)
                REG_SOUND_ENABLE:    sound_enable_reg      <= pwdata[0];
                REG_DOT_ON_TIME:     timing_reg.dot_on     <= pwdata[TIME_W-1:0];
                REG_DASH_ON_TIME:    timing_reg.dash_on    <= pwdata[TIME_W-1:0];
                REG_DOT_OFF_TIME:    timing_reg.dot_off    <= pwdata[TIME_W-1:0];
                REG_DASH_OFF_TIME:   timing_reg.dash_off   <= pwdata[TIME_W-1:0];
                REG_LETTER_GAP_TIME: timing_reg.letter_gap <= pwdata[TIME_W-1:0];
                REG_WORD_GAP_TIME:   timing_reg.word_gap   <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_SOUND_ENABLE:    prdata = APB_DATA_W'(sound_enable_reg);
            REG_DOT_ON_TIME:     prdata = APB_DATA_W'(timing_reg.dot_on);
            REG_DASH_ON_TIME:    prdata = APB_DATA_W'(timing_reg.dash_on);
            REG_DOT_OFF_TIME:    prdata = APB_DATA_W'(timing_reg.dot_off);
            REG_DASH_OFF_TIME:   prdata = APB_DATA_W'(timing_reg.dash_off);
            REG_LETTER_GAP_TIME: prdata = APB_DATA_W'(timing_reg.letter_gap);
            REG_WORD_GAP_TIME:   prdata = APB_DATA_W'(timing_reg.word_gap);
            default:             prdata = '0;
        endcase
    end

    mce_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .sound_enable (sound_enable_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    mce_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mce_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .timing         (timing_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_entry      (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segment_kind (m_segment_kind),
        .m_tone_time    (m_tone_time),
        .m_silence_time (m_silence_time),
        .m_last_segment (m_last_segment)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mce_front.sv =====
// Front end: accepts characters, looks them up and registers a queue entry.
// Depends on mce_pkg.
`default_nettype none
module mce_front
    import mce_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              sound_enable,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CHAR_W-1:0] s_character,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output entry_t                 push_entry
);

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;
    code_t  code;

    always_comb begin
        code       = morse_lookup(s_character);
        s_ready    = !valid_reg || push_ready;
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (push_ready) begin
            valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            valid_next          = 1'b1;
            entry_next.symbols  = code.symbols;
            entry_next.word_gap = sound_enable && !code.known;
            if (!sound_enable) begin
                entry_next.elem_count = '0;
            end else if (code.known) begin
                entry_next.elem_count = code.len;
            end else begin
                entry_next.elem_count = LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

endmodule
`default_nettype wire

// ===== rtl/core/mce_queue.sv =====
// Short FIFO of classified entries between front and back ends.
// Depends on mce_pkg.
`default_nettype none
module mce_queue
    import mce_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push_valid,
    output logic        push_ready,
    input  wire entry_t push_entry,
    output logic        pop_valid,
    input  wire logic   pop_ready,
    output entry_t      pop_entry
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    always_comb begin
        push_ready  = count_reg != FULL_CNT;
        pop_valid   = count_reg != '0;
        do_push     = push_valid && push_ready;
        do_pop      = pop_valid && pop_ready;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
        pop_entry = mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/mce_back.sv =====
// Back end: steps through one entry, one segment per cycle when the output is not
// stalled, into the output register. Depends on mce_pkg.
`default_nettype none
module mce_back
    import mce_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire timing_t            timing,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire entry_t             pop_entry,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_segment_kind,
    output logic [TIME_W-1:0]       m_tone_time,
    output logic [TIME_W-1:0]       m_silence_time,
    output logic                    m_last_segment
);

    logic                    cur_valid_reg, cur_valid_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;
    logic [CODE_MAX_LEN-1:0] sym_reg, sym_next;
    logic                    word_gap_reg, word_gap_next;

    logic                    m_valid_reg, m_valid_next;
    seg_kind_t               kind_reg, kind_next;
    logic [TIME_W-1:0]       tone_reg, tone_next;
    logic [TIME_W-1:0]       silence_reg, silence_next;
    logic                    last_reg, last_next;

    logic out_free, emit, at_gap;

    always_comb begin
        out_free       = !m_valid_reg || m_ready;
        emit           = cur_valid_reg && out_free;
        at_gap         = rem_reg == '0;
        pop_ready      = !cur_valid_reg || (emit && at_gap);

        cur_valid_next = cur_valid_reg;
        rem_next       = rem_reg;
        sym_next       = sym_reg;
        word_gap_next  = word_gap_reg;
        m_valid_next   = m_valid_reg;
        kind_next      = kind_reg;
        tone_next      = tone_reg;
        silence_next   = silence_reg;
        last_next      = last_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (emit) begin
            m_valid_next = 1'b1;
            if (at_gap) begin
                kind_next      = KIND_LETTER_GAP;
                tone_next      = '0;
                silence_next   = timing.letter_gap;
                last_next      = 1'b1;
                cur_valid_next = 1'b0;
            end else begin
                last_next = 1'b0;
                rem_next  = rem_reg - LEN_W'(1);
                sym_next  = {sym_reg[CODE_MAX_LEN-2:0], 1'b0};
                if (word_gap_reg) begin
                    kind_next    = KIND_WORD_GAP;
                    tone_next    = '0;
                    silence_next = timing.word_gap;
                end else if (sym_reg[CODE_MAX_LEN-1]) begin
                    kind_next    = KIND_DASH;
                    tone_next    = timing.dash_on;
                    silence_next = timing.dash_off;
                end else begin
                    kind_next    = KIND_DOT;
                    tone_next    = timing.dot_on;
                    silence_next = timing.dot_off;
                end
            end
        end

        if (pop_valid && pop_ready) begin
            cur_valid_next = 1'b1;
            rem_next       = pop_entry.elem_count;
            sym_next       = pop_entry.symbols;
            word_gap_next  = pop_entry.word_gap;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        rem_reg      <= rem_next;
        sym_reg      <= sym_next;
        word_gap_reg <= word_gap_next;
        kind_reg     <= kind_next;
        tone_reg     <= tone_next;
        silence_reg  <= silence_next;
        last_reg     <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_segment_kind = kind_reg;
    assign m_tone_time    = tone_reg;
    assign m_silence_time = silence_reg;
    assign m_last_segment = last_reg;

endmodule
`default_nettype wire
